FILE: rtl/sdp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdp_pkg
// Shared types, register indexes and fixed-point constants of the damped
// spring point update unit.
// ----------------------------------------------------------------------------
package sdp_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int ROOT_W    = 32;

    // Register indexes on the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VISCOSITY        = 3'd0,
        CFG_DAMPING          = 3'd1,
        CFG_SPEED_THRESHOLD  = 3'd2,
        CFG_BLOB_RADIUS      = 3'd3,
        CFG_MAX_SPEED_FACTOR = 3'd4,
        CFG_CENTER_X         = 3'd5,
        CFG_CENTER_Y         = 3'd6
    } cfg_idx_t;

    // Constants with 16 fraction bits (Q0.16, Q1.16 for 1.1): 0.03, 1.1 and 0.8
    localparam logic [10:0] PULL_IN_Q16 = 11'd1966;
    localparam logic [16:0] RING_Q16    = 17'd72090;
    localparam logic [15:0] BLEND_Q16   = 16'd52429;

    // Register reset values
    localparam logic [15:0] RST_VISCOSITY        = 16'd6554;
    localparam logic [16:0] RST_DAMPING          = 17'd62259;
    localparam logic [30:0] RST_SPEED_THRESHOLD  = 31'd6554;
    localparam logic [30:0] RST_BLOB_RADIUS      = 31'd16384000;
    localparam logic [23:0] RST_MAX_SPEED_FACTOR = 24'd13107;

    // Registers plus the values derived from them
    typedef struct packed {
        logic        [15:0] viscosity;
        logic        [16:0] damping;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic        [63:0] ring_sq_full;
        logic        [63:0] ring_sq_half;
        logic        [61:0] thr_sq;
        logic        [31:0] max_speed;
        logic        [63:0] max_sq;
    } cfg_t;

    // Side data beside the distance square root
    typedef struct packed {
        logic [32:0] fx;
        logic [32:0] fy;
        logic [30:0] sx;
        logic [30:0] sy;
        logic        neg_x;
        logic        neg_y;
        logic        outside;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] px;
        logic [31:0] py;
    } dist_side_t;

    // Side data beside the pull division
    typedef struct packed {
        logic [32:0] fx;
        logic [32:0] fy;
        logic        neg_x;
        logic        neg_y;
        logic        outside;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] px;
        logic [31:0] py;
    } pull_side_t;

    // Side data beside the speed square root
    typedef struct packed {
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] mag_x;
        logic [31:0] mag_y;
        logic        still;
        logic        fast;
        logic [31:0] px;
        logic [31:0] py;
    } speed_side_t;

    // Side data beside the speed clamp division
    typedef struct packed {
        logic [31:0] vx;
        logic [31:0] vy;
        logic        still;
        logic        fast;
        logic [31:0] px;
        logic [31:0] py;
    } clamp_side_t;

endpackage

FILE: rtl/sdp_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdp_cfg
// Configuration registers and the ring, threshold and speed limit values
// derived from them.
// ----------------------------------------------------------------------------
module sdp_cfg
    import sdp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [DATA_W-1:0]    wr_data,
    output cfg_t                 cfg
);

    localparam logic [63:0] RST_RING  = 64'd18022500;
    localparam logic [63:0] RST_HALF  = RST_RING >> 1;
    localparam logic [63:0] RST_MAX   = 64'd3276750;
    localparam logic [63:0] RST_THR   = 64'(RST_SPEED_THRESHOLD);

    logic        [15:0] viscosity_reg;
    logic        [16:0] damping_reg;
    logic        [30:0] thr_reg;
    logic        [30:0] radius_reg;
    logic        [23:0] factor_reg;
    logic signed [31:0] center_x_reg;
    logic signed [31:0] center_y_reg;
    logic        [31:0] ring_reg;
    logic        [63:0] ring_sq_full_reg;
    logic        [63:0] ring_sq_half_reg;
    logic        [61:0] thr_sq_reg;
    logic        [31:0] max_reg;
    logic        [63:0] max_sq_reg;

    logic [47:0] ring_prod;
    logic [54:0] max_prod;
    logic [31:0] ring_half;
    logic [31:0] max_next;

    // Take register writes; unknown indexes fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            viscosity_reg <= RST_VISCOSITY;
            damping_reg   <= RST_DAMPING;
            thr_reg       <= RST_SPEED_THRESHOLD;
            radius_reg    <= RST_BLOB_RADIUS;
            factor_reg    <= RST_MAX_SPEED_FACTOR;
            center_x_reg  <= '0;
            center_y_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (cfg_idx_t'(wr_index))
                CFG_VISCOSITY:        viscosity_reg <= wr_data[15:0];
                CFG_DAMPING:          damping_reg   <= wr_data[16:0];
                CFG_SPEED_THRESHOLD:  thr_reg       <= wr_data[30:0];
                CFG_BLOB_RADIUS:      radius_reg    <= wr_data[30:0];
                CFG_MAX_SPEED_FACTOR: factor_reg    <= wr_data[23:0];
                CFG_CENTER_X:         center_x_reg  <= wr_data;
                CFG_CENTER_Y:         center_y_reg  <= wr_data;
                default:              ;
            endcase
        end
    end

    // Ring radius 1.1*r rounded, and maximum speed clamped to 32 bits
    assign ring_prod = 48'(radius_reg) * 48'(RING_Q16) + 48'd32768;
    assign max_prod  = 55'(radius_reg) * 55'(factor_reg);
    assign max_next  = (|max_prod[54:48]) ? 32'hFFFF_FFFF : max_prod[47:16];
    assign ring_half = ring_reg >> 1;

    // Derive the squared limits over two register levels
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg         <= RST_RING[31:0];
            max_reg          <= RST_MAX[31:0];
            ring_sq_full_reg <= RST_RING * RST_RING;
            ring_sq_half_reg <= RST_HALF * RST_HALF;
            thr_sq_reg       <= 62'(RST_THR * RST_THR);
            max_sq_reg       <= RST_MAX * RST_MAX;
        end
        else
        begin
            ring_reg         <= ring_prod[47:16];
            max_reg          <= max_next;
            ring_sq_full_reg <= 64'(ring_reg) * 64'(ring_reg);
            ring_sq_half_reg <= 64'(ring_half) * 64'(ring_half);
            thr_sq_reg       <= 62'(thr_reg) * 62'(thr_reg);
            max_sq_reg       <= 64'(max_reg) * 64'(max_reg);
        end
    end

    assign cfg.viscosity    = viscosity_reg;
    assign cfg.damping      = damping_reg;
    assign cfg.center_x     = center_x_reg;
    assign cfg.center_y     = center_y_reg;
    assign cfg.ring_sq_full = ring_sq_full_reg;
    assign cfg.ring_sq_half = ring_sq_half_reg;
    assign cfg.thr_sq       = thr_sq_reg;
    assign cfg.max_speed    = max_reg;
    assign cfg.max_sq       = max_sq_reg;

endmodule

FILE: rtl/sdp_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdp_isqrt
// Pipelined integer square root, one root bit per stage, with a side word
// and a valid bit carried alongside.
// ----------------------------------------------------------------------------
module sdp_isqrt
    import sdp_pkg::*;
#(
    parameter int RW     = ROOT_W,
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [2*RW-1:0]   in_rad,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_vld,
    output logic [RW-1:0]     out_root,
    output logic [SIDE_W-1:0] out_side
);

    localparam int RAD_W = 2 * RW;

    logic [RAD_W-1:0]  rem_reg  [RW];
    logic [RAD_W-1:0]  root_reg [RW];
    logic [SIDE_W-1:0] side_reg [RW];
    logic [RW-1:0]     vld_reg;

    for (genvar k = 0; k < RW; k++)
    begin : g_step
        localparam logic [RAD_W-1:0] BIT_K = RAD_W'(1) << (RAD_W - 2 - 2 * k);

        logic [RAD_W-1:0]  cur_rem;
        logic [RAD_W-1:0]  cur_root;
        logic [SIDE_W-1:0] cur_side;
        logic              cur_vld;
        logic [RAD_W-1:0]  trial;
        logic              take;

        if (k == 0)
        begin : g_first
            assign cur_rem  = in_rad;
            assign cur_root = '0;
            assign cur_side = in_side;
            assign cur_vld  = in_vld;
        end
        else
        begin : g_next
            assign cur_rem  = rem_reg[k-1];
            assign cur_root = root_reg[k-1];
            assign cur_side = side_reg[k-1];
            assign cur_vld  = vld_reg[k-1];
        end

        // Try the next root bit against the remainder
        assign trial = cur_root + BIT_K;
        assign take  = cur_rem >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= cur_vld;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= take ? cur_rem - trial : cur_rem;
                root_reg[k] <= take ? (cur_root >> 1) + BIT_K : cur_root >> 1;
                side_reg[k] <= cur_side;
            end
        end
    end

    assign out_vld  = vld_reg[RW-1];
    assign out_root = root_reg[RW-1][RW-1:0];
    assign out_side = side_reg[RW-1];

endmodule

FILE: rtl/sdp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdp_div
// Two-lane pipelined restoring divider sharing one divisor, one quotient
// bit per stage, with a side word and a valid bit carried alongside.
// ----------------------------------------------------------------------------
module sdp_div #(
    parameter int NUM_W  = 43,
    parameter int DEN_W  = 32,
    parameter int QUO_W  = 11,
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [NUM_W-1:0]  in_num_a,
    input  logic [NUM_W-1:0]  in_num_b,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_vld,
    output logic [QUO_W-1:0]  out_quo_a,
    output logic [QUO_W-1:0]  out_quo_b,
    output logic [SIDE_W-1:0] out_side
);

    localparam int WW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [WW-1:0]     rem_a_reg [QUO_W];
    logic [WW-1:0]     rem_b_reg [QUO_W];
    logic [QUO_W-1:0]  quo_a_reg [QUO_W];
    logic [QUO_W-1:0]  quo_b_reg [QUO_W];
    logic [DEN_W-1:0]  den_reg   [QUO_W];
    logic [SIDE_W-1:0] side_reg  [QUO_W];
    logic [QUO_W-1:0]  vld_reg;

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_step
        localparam int SH = QUO_W - 1 - k;

        logic [WW-1:0]     cur_rem_a;
        logic [WW-1:0]     cur_rem_b;
        logic [QUO_W-1:0]  cur_quo_a;
        logic [QUO_W-1:0]  cur_quo_b;
        logic [DEN_W-1:0]  cur_den;
        logic [SIDE_W-1:0] cur_side;
        logic              cur_vld;
        logic [WW-1:0]     den_sh;
        logic              take_a;
        logic              take_b;

        if (k == 0)
        begin : g_first
            assign cur_rem_a = WW'(in_num_a);
            assign cur_rem_b = WW'(in_num_b);
            assign cur_quo_a = '0;
            assign cur_quo_b = '0;
            assign cur_den   = in_den;
            assign cur_side  = in_side;
            assign cur_vld   = in_vld;
        end
        else
        begin : g_next
            assign cur_rem_a = rem_a_reg[k-1];
            assign cur_rem_b = rem_b_reg[k-1];
            assign cur_quo_a = quo_a_reg[k-1];
            assign cur_quo_b = quo_b_reg[k-1];
            assign cur_den   = den_reg[k-1];
            assign cur_side  = side_reg[k-1];
            assign cur_vld   = vld_reg[k-1];
        end

        // Subtract the shifted divisor where it fits
        assign den_sh = WW'(cur_den) << SH;
        assign take_a = cur_rem_a >= den_sh;
        assign take_b = cur_rem_b >= den_sh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= cur_vld;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_a_reg[k] <= take_a ? cur_rem_a - den_sh : cur_rem_a;
                rem_b_reg[k] <= take_b ? cur_rem_b - den_sh : cur_rem_b;
                quo_a_reg[k] <= cur_quo_a | (QUO_W'(take_a) << SH);
                quo_b_reg[k] <= cur_quo_b | (QUO_W'(take_b) << SH);
                den_reg[k]   <= cur_den;
                side_reg[k]  <= cur_side;
            end
        end
    end

    assign out_vld   = vld_reg[QUO_W-1];
    assign out_quo_a = quo_a_reg[QUO_W-1];
    assign out_quo_b = quo_b_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule

FILE: rtl/spring_damped_point_update_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spring_damped_point_update_unit
// Advances one 2-D control point per word: spring pull, center pull, damping,
// still detection, speed clamp and position integration in Q16.16.
//
//   channel | dir | handshake              | payload
//   s_axis  | in  | s_axis_tvalid/tready   | pos, target, velocity (192 bits)
//   m_axis  | out | m_axis_tvalid/tready   | new pos, new velocity, moving
//   cfg     | in  | cfg_valid/cfg_ready    | register index, 32-bit data
//
// One word enters per cycle while the pipe is not held; each word passes
// 120 register levels from input to output, set mostly by the two 32-step square
// roots and the 11- and 32-step dividers, one step per stage.
// A two-deep output register (output plus skid) parts the sides; the pipe
// holds while the skid word waits. Reset clears valid bits and loads the
// register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module spring_damped_point_update_unit
    import sdp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // pos_x, pos_y, target_x, target_y, vel_x, vel_y
    input  logic [191:0]         s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // new_pos_x, new_pos_y, new_vel_x, new_vel_y
    output logic [127:0]         m_axis_tdata,
    // moving
    output logic [0:0]           m_axis_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    cfg_t cfg;
    logic pipe_en;

    assign cfg_ready = 1'b1;

    sdp_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // ------------------------------------------------------------------
    // Stage 1: capture the word
    logic         s1_vld_reg;
    logic [191:0] s1_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (pipe_en)
            s1_vld_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
            s1_word_reg <= s_axis_tdata;
    end

    // ------------------------------------------------------------------
    // Stage 2: differences, spring product, center vector magnitude
    logic        [31:0] px1, py1, tx1, ty1, vx1, vy1;
    logic signed [32:0] dx_c, dy_c, cx_c, cy_c;
    logic signed [49:0] fpx_c, fpy_c;
    logic        [32:0] ax_c, ay_c;
    logic               big_c;

    assign px1 = s1_word_reg[31:0];
    assign py1 = s1_word_reg[63:32];
    assign tx1 = s1_word_reg[95:64];
    assign ty1 = s1_word_reg[127:96];
    assign vx1 = s1_word_reg[159:128];
    assign vy1 = s1_word_reg[191:160];

    assign dx_c  = {tx1[31], tx1} - {px1[31], px1};
    assign dy_c  = {ty1[31], ty1} - {py1[31], py1};
    assign cx_c  = {cfg.center_x[31], cfg.center_x} - {px1[31], px1};
    assign cy_c  = {cfg.center_y[31], cfg.center_y} - {py1[31], py1};
    assign fpx_c = dx_c * $signed({1'b0, cfg.viscosity});
    assign fpy_c = dy_c * $signed({1'b0, cfg.viscosity});
    assign ax_c  = cx_c[32] ? 33'(-cx_c) : 33'(cx_c);
    assign ay_c  = cy_c[32] ? 33'(-cy_c) : 33'(cy_c);
    assign big_c = ax_c[32] | ax_c[31] | ay_c[32] | ay_c[31];

    logic               s2_vld_reg;
    logic signed [49:0] s2_fpx_reg, s2_fpy_reg;
    logic        [30:0] s2_sx_reg, s2_sy_reg;
    logic               s2_negx_reg, s2_negy_reg, s2_big_reg;
    logic        [31:0] s2_vx_reg, s2_vy_reg, s2_px_reg, s2_py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (pipe_en)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s2_fpx_reg  <= fpx_c;
            s2_fpy_reg  <= fpy_c;
            s2_sx_reg   <= big_c ? ax_c[31:1] : ax_c[30:0];
            s2_sy_reg   <= big_c ? ay_c[31:1] : ay_c[30:0];
            s2_negx_reg <= cx_c[32];
            s2_negy_reg <= cy_c[32];
            s2_big_reg  <= big_c;
            s2_vx_reg   <= vx1;
            s2_vy_reg   <= vy1;
            s2_px_reg   <= px1;
            s2_py_reg   <= py1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: round the force, square the scaled center vector
    logic [49:0] fxr_c, fyr_c;

    assign fxr_c = s2_fpx_reg + 50'sd32768;
    assign fyr_c = s2_fpy_reg + 50'sd32768;

    logic        s3_vld_reg;
    logic [32:0] s3_fx_reg, s3_fy_reg;
    logic [61:0] s3_sqx_reg, s3_sqy_reg;
    logic [30:0] s3_sx_reg, s3_sy_reg;
    logic        s3_negx_reg, s3_negy_reg, s3_big_reg;
    logic [31:0] s3_vx_reg, s3_vy_reg, s3_px_reg, s3_py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else if (pipe_en)
            s3_vld_reg <= s2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s3_fx_reg   <= fxr_c[48:16];
            s3_fy_reg   <= fyr_c[48:16];
            s3_sqx_reg  <= 62'(s2_sx_reg) * 62'(s2_sx_reg);
            s3_sqy_reg  <= 62'(s2_sy_reg) * 62'(s2_sy_reg);
            s3_sx_reg   <= s2_sx_reg;
            s3_sy_reg   <= s2_sy_reg;
            s3_negx_reg <= s2_negx_reg;
            s3_negy_reg <= s2_negy_reg;
            s3_big_reg  <= s2_big_reg;
            s3_vx_reg   <= s2_vx_reg;
            s3_vy_reg   <= s2_vy_reg;
            s3_px_reg   <= s2_px_reg;
            s3_py_reg   <= s2_py_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: squared distance and the ring test
    logic [63:0] d2_c;
    logic [63:0] ring_c;

    assign d2_c   = 64'(s3_sqx_reg) + 64'(s3_sqy_reg);
    assign ring_c = s3_big_reg ? cfg.ring_sq_half : cfg.ring_sq_full;

    logic       s4_vld_reg;
    logic [63:0] s4_d2_reg;
    dist_side_t s4_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_vld_reg <= 1'b0;
        else if (pipe_en)
            s4_vld_reg <= s3_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s4_d2_reg           <= d2_c;
            s4_side_reg.fx      <= s3_fx_reg;
            s4_side_reg.fy      <= s3_fy_reg;
            s4_side_reg.sx      <= s3_sx_reg;
            s4_side_reg.sy      <= s3_sy_reg;
            s4_side_reg.neg_x   <= s3_negx_reg;
            s4_side_reg.neg_y   <= s3_negy_reg;
            s4_side_reg.outside <= d2_c > ring_c;
            s4_side_reg.vx      <= s3_vx_reg;
            s4_side_reg.vy      <= s3_vy_reg;
            s4_side_reg.px      <= s3_px_reg;
            s4_side_reg.py      <= s3_py_reg;
        end
    end

    // ------------------------------------------------------------------
    // Distance square root
    logic              dq_vld;
    logic [ROOT_W-1:0] dq_len;
    dist_side_t        dq_side;

    sdp_isqrt #(
        .RW     (ROOT_W),
        .SIDE_W ($bits(dist_side_t))
    ) u_dist_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_vld   (s4_vld_reg),
        .in_rad   (s4_d2_reg),
        .in_side  (s4_side_reg),
        .out_vld  (dq_vld),
        .out_root (dq_len),
        .out_side (dq_side)
    );

    // ------------------------------------------------------------------
    // Stage 5: pull numerators with half-divisor rounding
    logic        s5_vld_reg;
    logic [42:0] s5_numx_reg, s5_numy_reg;
    logic [31:0] s5_len_reg;
    pull_side_t  s5_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_vld_reg <= 1'b0;
        else if (pipe_en)
            s5_vld_reg <= dq_vld;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s5_numx_reg <= 43'(dq_side.sx) * 43'(PULL_IN_Q16) + 43'(dq_len >> 1);
            s5_numy_reg <= 43'(dq_side.sy) * 43'(PULL_IN_Q16) + 43'(dq_len >> 1);
            s5_len_reg  <= dq_len;
            s5_side_reg.fx      <= dq_side.fx;
            s5_side_reg.fy      <= dq_side.fy;
            s5_side_reg.neg_x   <= dq_side.neg_x;
            s5_side_reg.neg_y   <= dq_side.neg_y;
            s5_side_reg.outside <= dq_side.outside;
            s5_side_reg.vx      <= dq_side.vx;
            s5_side_reg.vy      <= dq_side.vy;
            s5_side_reg.px      <= dq_side.px;
            s5_side_reg.py      <= dq_side.py;
        end
    end

    // ------------------------------------------------------------------
    // Pull division
    logic        pd_vld;
    logic [10:0] pd_qx, pd_qy;
    pull_side_t  pd_side;

    sdp_div #(
        .NUM_W  (43),
        .DEN_W  (32),
        .QUO_W  (11),
        .SIDE_W ($bits(pull_side_t))
    ) u_pull_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_vld    (s5_vld_reg),
        .in_num_a  (s5_numx_reg),
        .in_num_b  (s5_numy_reg),
        .in_den    (s5_len_reg),
        .in_side   (s5_side_reg),
        .out_vld   (pd_vld),
        .out_quo_a (pd_qx),
        .out_quo_b (pd_qy),
        .out_side  (pd_side)
    );

    // ------------------------------------------------------------------
    // Stage 6: add the center pull, blend product
    logic [33:0] pullx_c, pully_c, fx2_c, fy2_c;

    assign pullx_c = !pd_side.outside ? 34'd0 :
                     (pd_side.neg_x ? -34'(pd_qx) : 34'(pd_qx));
    assign pully_c = !pd_side.outside ? 34'd0 :
                     (pd_side.neg_y ? -34'(pd_qy) : 34'(pd_qy));
    assign fx2_c   = {pd_side.fx[32], pd_side.fx} + pullx_c;
    assign fy2_c   = {pd_side.fy[32], pd_side.fy} + pully_c;

    logic               s6_vld_reg;
    logic signed [50:0] s6_bx_reg, s6_by_reg;
    logic        [31:0] s6_vx_reg, s6_vy_reg, s6_px_reg, s6_py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_vld_reg <= 1'b0;
        else if (pipe_en)
            s6_vld_reg <= pd_vld;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s6_bx_reg <= $signed(fx2_c) * $signed({1'b0, BLEND_Q16});
            s6_by_reg <= $signed(fy2_c) * $signed({1'b0, BLEND_Q16});
            s6_vx_reg <= pd_side.vx;
            s6_vy_reg <= pd_side.vy;
            s6_px_reg <= pd_side.px;
            s6_py_reg <= pd_side.py;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: round the blend, add to velocity
    logic [50:0] bxr_c, byr_c;

    assign bxr_c = s6_bx_reg + 51'sd32768;
    assign byr_c = s6_by_reg + 51'sd32768;

    logic        s7_vld_reg;
    logic [34:0] s7_v1x_reg, s7_v1y_reg;
    logic [31:0] s7_px_reg, s7_py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s7_vld_reg <= 1'b0;
        else if (pipe_en)
            s7_vld_reg <= s6_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s7_v1x_reg <= {{3{s6_vx_reg[31]}}, s6_vx_reg} + bxr_c[50:16];
            s7_v1y_reg <= {{3{s6_vy_reg[31]}}, s6_vy_reg} + byr_c[50:16];
            s7_px_reg  <= s6_px_reg;
            s7_py_reg  <= s6_py_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: damping product
    logic               s8_vld_reg;
    logic signed [52:0] s8_dx_reg, s8_dy_reg;
    logic        [31:0] s8_px_reg, s8_py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s8_vld_reg <= 1'b0;
        else if (pipe_en)
            s8_vld_reg <= s7_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s8_dx_reg <= $signed(s7_v1x_reg) * $signed({1'b0, cfg.damping});
            s8_dy_reg <= $signed(s7_v1y_reg) * $signed({1'b0, cfg.damping});
            s8_px_reg <= s7_px_reg;
            s8_py_reg <= s7_py_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 9: round and saturate the damped velocity
    logic [52:0] dxr_c, dyr_c;
    logic [36:0] rx_c, ry_c;
    logic [31:0] v2x_c, v2y_c;

    assign dxr_c = s8_dx_reg + 53'sd32768;
    assign dyr_c = s8_dy_reg + 53'sd32768;
    assign rx_c  = dxr_c[52:16];
    assign ry_c  = dyr_c[52:16];
    assign v2x_c = (&rx_c[36:31] || ~|rx_c[36:31]) ? rx_c[31:0] :
                   (rx_c[36] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    assign v2y_c = (&ry_c[36:31] || ~|ry_c[36:31]) ? ry_c[31:0] :
                   (ry_c[36] ? 32'h8000_0000 : 32'h7FFF_FFFF);

    logic        s9_vld_reg;
    logic [31:0] s9_vx_reg, s9_vy_reg, s9_px_reg, s9_py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s9_vld_reg <= 1'b0;
        else if (pipe_en)
            s9_vld_reg <= s8_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s9_vx_reg <= v2x_c;
            s9_vy_reg <= v2y_c;
            s9_px_reg <= s8_px_reg;
            s9_py_reg <= s8_py_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 10: speed magnitudes and squares
    logic [31:0] magx_c, magy_c;

    assign magx_c = s9_vx_reg[31] ? -s9_vx_reg : s9_vx_reg;
    assign magy_c = s9_vy_reg[31] ? -s9_vy_reg : s9_vy_reg;

    logic        s10_vld_reg;
    logic [63:0] s10_sqx_reg, s10_sqy_reg;
    logic [31:0] s10_magx_reg, s10_magy_reg;
    logic [31:0] s10_vx_reg, s10_vy_reg, s10_px_reg, s10_py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s10_vld_reg <= 1'b0;
        else if (pipe_en)
            s10_vld_reg <= s9_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s10_sqx_reg  <= 64'(magx_c) * 64'(magx_c);
            s10_sqy_reg  <= 64'(magy_c) * 64'(magy_c);
            s10_magx_reg <= magx_c;
            s10_magy_reg <= magy_c;
            s10_vx_reg   <= s9_vx_reg;
            s10_vy_reg   <= s9_vy_reg;
            s10_px_reg   <= s9_px_reg;
            s10_py_reg   <= s9_py_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 11: speed squared against threshold and limit
    logic [63:0] sp2_c;

    assign sp2_c = s10_sqx_reg + s10_sqy_reg;

    logic        s11_vld_reg;
    logic [63:0] s11_sp2_reg;
    speed_side_t s11_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s11_vld_reg <= 1'b0;
        else if (pipe_en)
            s11_vld_reg <= s10_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s11_sp2_reg        <= sp2_c;
            s11_side_reg.vx    <= s10_vx_reg;
            s11_side_reg.vy    <= s10_vy_reg;
            s11_side_reg.mag_x <= s10_magx_reg;
            s11_side_reg.mag_y <= s10_magy_reg;
            s11_side_reg.still <= sp2_c < 64'(cfg.thr_sq);
            s11_side_reg.fast  <= sp2_c > cfg.max_sq;
            s11_side_reg.px    <= s10_px_reg;
            s11_side_reg.py    <= s10_py_reg;
        end
    end

    // ------------------------------------------------------------------
    // Speed square root
    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    speed_side_t       sq_side;

    sdp_isqrt #(
        .RW     (ROOT_W),
        .SIDE_W ($bits(speed_side_t))
    ) u_speed_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_vld   (s11_vld_reg),
        .in_rad   (s11_sp2_reg),
        .in_side  (s11_side_reg),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_side (sq_side)
    );

    // ------------------------------------------------------------------
    // Stage 12: clamp numerators with half-divisor rounding
    logic        s12_vld_reg;
    logic [64:0] s12_numx_reg, s12_numy_reg;
    logic [31:0] s12_q_reg;
    clamp_side_t s12_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s12_vld_reg <= 1'b0;
        else if (pipe_en)
            s12_vld_reg <= sq_vld;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s12_numx_reg <= 65'(sq_side.mag_x) * 65'(cfg.max_speed) + 65'(sq_root >> 1);
            s12_numy_reg <= 65'(sq_side.mag_y) * 65'(cfg.max_speed) + 65'(sq_root >> 1);
            s12_q_reg    <= sq_root;
            s12_side_reg.vx    <= sq_side.vx;
            s12_side_reg.vy    <= sq_side.vy;
            s12_side_reg.still <= sq_side.still;
            s12_side_reg.fast  <= sq_side.fast;
            s12_side_reg.px    <= sq_side.px;
            s12_side_reg.py    <= sq_side.py;
        end
    end

    // ------------------------------------------------------------------
    // Speed clamp division
    logic        cd_vld;
    logic [31:0] cd_qx, cd_qy;
    clamp_side_t cd_side;

    sdp_div #(
        .NUM_W  (65),
        .DEN_W  (32),
        .QUO_W  (32),
        .SIDE_W ($bits(clamp_side_t))
    ) u_clamp_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_vld    (s12_vld_reg),
        .in_num_a  (s12_numx_reg),
        .in_num_b  (s12_numy_reg),
        .in_den    (s12_q_reg),
        .in_side   (s12_side_reg),
        .out_vld   (cd_vld),
        .out_quo_a (cd_qx),
        .out_quo_b (cd_qy),
        .out_side  (cd_side)
    );

    // ------------------------------------------------------------------
    // Final velocity select and position integration
    logic [31:0] vfx_c, vfy_c;
    logic [32:0] npx_c, npy_c;
    logic [31:0] npx_sat, npy_sat;
    logic [127:0] res_data;
    logic         res_moving;

    always_comb
    begin
        priority if (cd_side.still)
        begin
            vfx_c = '0;
            vfy_c = '0;
        end
        else if (cd_side.fast)
        begin
            vfx_c = cd_side.vx[31] ? -cd_qx : cd_qx;
            vfy_c = cd_side.vy[31] ? -cd_qy : cd_qy;
        end
        else
        begin
            vfx_c = cd_side.vx;
            vfy_c = cd_side.vy;
        end
    end

    assign npx_c   = {cd_side.px[31], cd_side.px} + {vfx_c[31], vfx_c};
    assign npy_c   = {cd_side.py[31], cd_side.py} + {vfy_c[31], vfy_c};
    assign npx_sat = (npx_c[32] == npx_c[31]) ? npx_c[31:0] :
                     (npx_c[32] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    assign npy_sat = (npy_c[32] == npy_c[31]) ? npy_c[31:0] :
                     (npy_c[32] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    assign res_data   = {vfy_c, vfx_c, npy_sat, npx_sat};
    assign res_moving = !cd_side.still;

    // ------------------------------------------------------------------
    // Output register with skid; the pipe holds while the skid is full
    logic         out_valid_reg, skid_valid_reg;
    logic [127:0] out_data_reg, skid_data_reg;
    logic         out_user_reg, skid_user_reg;
    logic         out_free;
    logic         res_take;

    assign pipe_en  = !skid_valid_reg;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign res_take = pipe_en && cd_vld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || res_take;
            skid_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res_data;
            out_user_reg <= skid_valid_reg ? skid_user_reg : res_moving;
        end
        else if (res_take)
        begin
            skid_data_reg <= res_data;
            skid_user_reg <= res_moving;
        end
    end

    assign s_axis_tready   = pipe_en;
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_user_reg;

    // ------------------------------------------------------------------
    // Checks
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held without an output word");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_axis_tready))
        else $error("skid filled while the output was free");

    a_still_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[127:64] == '0))
        else $error("still point carries a nonzero velocity");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !m_axis_tready) |=> skid_valid_reg)
        else $error("skid word lost during a stall");

endmodule

FILE: tb/sv/spring_damped_point_update_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spring_damped_point_update_unit_test
// Self-checking bench for the damped spring point update unit. A directed
// table and random control points are streamed in across several register
// settings. Random stalls hit both sides of the block, and one long output
// hold-off fills the pipe. Each output word is checked against a local
// fixed-point model of the update, or against a listed result for known rows.
// ----------------------------------------------------------------------------
module spring_damped_point_update_unit_test;
    import sdp_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE       = 150;

    typedef struct {
        logic signed [31:0] px, py, tx, ty, vx, vy;
    } point_t;

    typedef struct packed {
        logic signed [31:0] px, py, vx, vy;
        logic               moving;
    } update_t;

    typedef struct {
        point_t  pt;
        bit      known;
        update_t upd;
    } row_t;

    typedef struct {
        logic [15:0]        visc;
        logic [16:0]        damp;
        logic [30:0]        thr;
        logic [30:0]        rad;
        logic [23:0]        msf;
        logic signed [31:0] cx, cy;
    } regs_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data = '0;

    regs_t   regs;
    update_t pending_updates[$];
    int      mismatches = 0;
    int      cycles = 0;
    bit      out_idle_ok = 1'b1;
    int      hold_reqs = 0;

    spring_damped_point_update_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint rnd16(longint x);
        return (x + 32768) >>> 16;
    endfunction

    function automatic longint clip32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint unsigned abs64(longint x);
        return (x < 0) ? longint'(-x) : longint'(x);
    endfunction

    // Spring pull, center pull, blend, damping, still check, clamp, integrate
    function automatic update_t advance_point(point_t p);
        longint px, py, vx, vy, fx, fy, cx, cy;
        longint unsigned ax, ay, ring, sx, sy, ts, d2, len, sp2, thr2, vmax, q;
        int sh;
        update_t u;
        px = p.px; py = p.py; vx = p.vx; vy = p.vy;
        fx = rnd16((longint'(p.tx) - px) * longint'({1'b0, regs.visc}));
        fy = rnd16((longint'(p.ty) - py) * longint'({1'b0, regs.visc}));
        cx = longint'(regs.cx) - px;
        cy = longint'(regs.cy) - py;
        ax = abs64(cx);
        ay = abs64(cy);
        ring = (longint'(regs.rad) * longint'(RING_Q16) + 32768) >> 16;
        sh = (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) ? 1 : 0;
        sx = ax >> sh;
        sy = ay >> sh;
        ts = ring >> sh;
        d2 = sx * sx + sy * sy;
        // Outside the ring: nudge toward the center
        if (d2 > ts * ts)
        begin
            len = int_sqrt(d2);
            ax = (sx * PULL_IN_Q16 + len / 2) / len;
            ay = (sy * PULL_IN_Q16 + len / 2) / len;
            fx = (cx < 0) ? fx - longint'(ax) : fx + longint'(ax);
            fy = (cy < 0) ? fy - longint'(ay) : fy + longint'(ay);
        end
        vx = vx + rnd16(fx * longint'(BLEND_Q16));
        vy = vy + rnd16(fy * longint'(BLEND_Q16));
        vx = clip32(rnd16(vx * longint'({1'b0, regs.damp})));
        vy = clip32(rnd16(vy * longint'({1'b0, regs.damp})));
        sp2 = abs64(vx) * abs64(vx) + abs64(vy) * abs64(vy);
        thr2 = longint'(regs.thr) * longint'(regs.thr);
        vmax = (longint'(regs.rad) * longint'(regs.msf)) >> 16;
        if (vmax > 64'hFFFF_FFFF) vmax = 64'hFFFF_FFFF;
        if (sp2 < thr2)
        begin
            vx = 0;
            vy = 0;
            u.moving = 1'b0;
        end
        else
        begin
            u.moving = 1'b1;
            if (sp2 > vmax * vmax)
            begin
                q = int_sqrt(sp2);
                ax = (abs64(vx) * vmax + q / 2) / q;
                ay = (abs64(vy) * vmax + q / 2) / q;
                vx = (vx < 0) ? -longint'(ax) : longint'(ax);
                vy = (vy < 0) ? -longint'(ay) : longint'(ay);
            end
        end
        u.px = 32'(clip32(px + vx));
        u.py = 32'(clip32(py + vy));
        u.vx = 32'(vx);
        u.vy = 32'(vy);
        return u;
    endfunction

    // Output side: random stall bursts plus the requested long hold-off
    initial
    begin : out_driver
        int stall;
        int hold;
        int holds_done;
        stall = 0;
        hold = 0;
        holds_done = 0;
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_reqs)
            begin
                holds_done = holds_done + 1;
                hold = 400;
            end
            if (hold > 0)
            begin
                hold = hold - 1;
                m_axis_tready = 1'b0;
            end
            else if (stall > 0)
            begin
                stall = stall - 1;
                m_axis_tready = 1'b0;
            end
            else if (out_idle_ok && $urandom_range(0, 9) == 0)
            begin
                stall = $urandom_range(0, 11);
                m_axis_tready = 1'b0;
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    // Compare each output word with the oldest expected update
    always @(posedge clk)
    begin
        update_t e;
        update_t a;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            a.px = m_axis_tdata[31:0];
            a.py = m_axis_tdata[63:32];
            a.vx = m_axis_tdata[95:64];
            a.vy = m_axis_tdata[127:96];
            a.moving = m_axis_tuser[0];
            if (pending_updates.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected output word: pos %0d,%0d vel %0d,%0d mv %0d",
                             a.px, a.py, a.vx, a.vy, a.moving);
            end
            else
            begin
                e = pending_updates.pop_front();
                if (a != e)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display({"mismatch: exp pos %0d,%0d vel %0d,%0d mv %0d",
                                  " got pos %0d,%0d vel %0d,%0d mv %0d"},
                                 e.px, e.py, e.vx, e.vy, e.moving,
                                 a.px, a.py, a.vx, a.vy, a.moving);
                end
            end
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_VISCOSITY:        regs.visc = val[15:0];
            CFG_DAMPING:          regs.damp = val[16:0];
            CFG_SPEED_THRESHOLD:  regs.thr = val[30:0];
            CFG_BLOB_RADIUS:      regs.rad = val[30:0];
            CFG_MAX_SPEED_FACTOR: regs.msf = val[23:0];
            CFG_CENTER_X:         regs.cx = val;
            CFG_CENTER_Y:         regs.cy = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_regs(regs_t r);
        write_reg(CFG_VISCOSITY, 32'(r.visc));
        write_reg(CFG_DAMPING, 32'(r.damp));
        write_reg(CFG_SPEED_THRESHOLD, 32'(r.thr));
        write_reg(CFG_BLOB_RADIUS, 32'(r.rad));
        write_reg(CFG_MAX_SPEED_FACTOR, 32'(r.msf));
        write_reg(CFG_CENTER_X, r.cx);
        write_reg(CFG_CENTER_Y, r.cy);
    endtask

    // Offer one word, hold it until taken, then maybe drop valid for a burst
    task automatic send_point(point_t p, bit known, update_t upd, bit idle_ok);
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {p.vy, p.vx, p.ty, p.tx, p.py, p.px};
        do @(posedge clk); while (!s_axis_tready);
        pending_updates.push_back(known ? upd : advance_point(p));
        if (idle_ok && $urandom_range(0, 7) == 0)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(0, 11)) @(negedge clk);
        end
    endtask

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom();
            2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
        endcase
    endfunction

    function automatic point_t rnd_point();
        point_t p;
        p.px = rnd_coord();
        p.py = rnd_coord();
        p.tx = rnd_coord();
        p.ty = rnd_coord();
        p.vx = ($urandom_range(0, 3) == 0) ? $urandom()
             : 32'($signed($urandom_range(0, 32'h007F_FFFF)) - 32'sh0040_0000);
        p.vy = ($urandom_range(0, 3) == 0) ? $urandom()
             : 32'($signed($urandom_range(0, 32'h007F_FFFF)) - 32'sh0040_0000);
        return p;
    endfunction

    task automatic wait_drained();
        wait (pending_updates.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin : main_flow
        row_t    rows[$];
        regs_t   sets[$];
        regs_t   r;
        row_t    w;
        update_t none;
        update_t zero;
        int      n;
        none = '{0, 0, 0, 0, 0};
        zero = '{0, 0, 0, 0, 0};

        regs = '{RST_VISCOSITY, RST_DAMPING, RST_SPEED_THRESHOLD, RST_BLOB_RADIUS,
                 RST_MAX_SPEED_FACTOR, 0, 0};

        // Directed table: all zero and a still point at rest are known outright
        rows.push_back('{'{0, 0, 0, 0, 0, 0}, 1'b1, zero});
        rows.push_back('{'{1000, -1000, 1000, -1000, 0, 0}, 1'b1,
                         '{1000, -1000, 0, 0, 1'b0}});
        rows.push_back('{'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                           0, 0}, 1'b0, none});
        rows.push_back('{'{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           0, 0}, 1'b0, none});
        rows.push_back('{'{0, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0, none});
        rows.push_back('{'{0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000}, 1'b0, none});
        rows.push_back('{'{32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0},
                         1'b0, none});
        rows.push_back('{'{32'h8000_0000, 0, 32'h8000_0000, 0, 32'h8000_0000, 0},
                         1'b0, none});
        rows.push_back('{'{32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000,
                           0, 0}, 1'b0, none});
        rows.push_back('{'{32'h00F0_0000, 0, 32'h0080_0000, 0, 32'h0030_0000,
                           32'hFFD0_0000}, 1'b0, none});
        rows.push_back('{'{32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 0, 100, -100},
                         1'b0, none});
        rows.push_back('{'{0, 0, 0, 0, 6000, 0}, 1'b0, none});
        rows.push_back('{'{0, 0, 0, 0, 6554, 0}, 1'b0, none});
        rows.push_back('{'{0, 0, 0, 0, 32'h0500_0000, 32'h0500_0000}, 1'b0, none});
        rows.push_back('{'{-1, -1, -1, -1, -1, -1}, 1'b0, none});

        // Register settings, extremes included
        sets.push_back('{6554, 62259, 6554, 31'd16384000, 13107,
                         32'sh0064_0000, -32'sh0032_0000});
        sets.push_back('{16'hFFFF, 17'h10000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 24'hFF_FFFF,
                         32'sh7FFF_FFFF, 32'h8000_0000});
        sets.push_back('{0, 0, 0, 0, 0, 32'h8000_0000, 32'sh7FFF_FFFF});
        sets.push_back('{16'hFFFF, 17'h10000, 0, 31'h0032_0000, 24'h02_0000, 0, 0});
        r.visc = 16'($urandom()); r.damp = 17'($urandom_range(0, 65536));
        r.thr = 31'($urandom()); r.rad = 31'($urandom()); r.msf = 24'($urandom());
        r.cx = $urandom(); r.cy = $urandom();
        sets.push_back(r);
        sets.push_back('{6554, 62259, 300, 31'h0040_0000, 24'h00_8000,
                         -32'sh0010_0000, 32'sh0020_0000});

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
        begin
            w = rows[i];
            send_point(w.pt, w.known, w.upd, 1'b1);
        end

        foreach (sets[k])
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            wait_drained();
            load_regs(sets[k]);
            n = 0;
            repeat (240)
            begin
                // Long output hold-off while input keeps coming
                if (k == 0 && n == 30) hold_reqs = hold_reqs + 1;
                if (k == sets.size() - 1 && n == 120) out_idle_ok = 1'b0;
                send_point(rnd_point(), 1'b0, none, !(k == sets.size() - 1 && n >= 120));
                n = n + 1;
            end
        end
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        wait_drained();

        if (mismatches == 0 && pending_updates.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
rtl/sdp_pkg.sv
rtl/sdp_cfg.sv
rtl/sdp_isqrt.sv
rtl/sdp_div.sv
rtl/spring_damped_point_update_unit.sv
tb/sv/spring_damped_point_update_unit_test.sv
